// ===== sv/skft_pkg.sv =====
// Shared types and constants for the sorted keyframe table.
// No dependencies; imported by the interfaces, the cell and the top level.
`default_nettype none
package skft_pkg;

	localparam int FRAME_W   = 32;
	localparam int CMD_W     = 3;
	localparam int IDX_OUT_W = 6;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_FIND    = 3'd2,
		CMD_NEXT    = 3'd3,
		CMD_PREV    = 3'd4,
		CMD_CLOSEST = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_EXEC = 4'b1000
	} state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic g;
		logic e;
		logic eq;
	} cell_flags_t;

endpackage
`default_nettype wire

// ===== sv/skft_if.sv =====
// Request and response channel interfaces for the sorted keyframe table.
// Depends on skft_pkg for field widths.
`default_nettype none
interface skft_req_if
	import skft_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [FRAME_W-1:0] frame;

	modport source (output valid, command, frame, input ready);
	modport sink (input valid, command, frame, output ready);
endinterface

interface skft_rsp_if
	import skft_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [FRAME_W-1:0]   result_frame;
	logic [IDX_OUT_W-1:0] result_index;
	logic [CNT_OUT_W-1:0] key_count;
	logic [1:0]           status;

	modport source (output valid, found, result_frame, result_index, key_count, status,
		input ready);
	modport sink (input valid, found, result_frame, result_index, key_count, status,
		output ready);
endinterface
`default_nettype wire

// ===== sv/skft_cell.sv =====
// One slot of the sorted key row: holds a key, compares it with the broadcast
// frame and shifts to or from its neighbours on insert and remove. Uses skft_pkg.
`default_nettype none
module skft_cell
	import skft_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic [FRAME_W-1:0] frame,
	input  wire logic [FRAME_W-1:0] left_key,
	input  wire logic               left_valid,
	input  wire logic               left_g,
	input  wire logic [FRAME_W-1:0] right_key,
	input  wire logic               right_valid,
	output logic [FRAME_W-1:0]      key,
	output cell_flags_t             flags
);

	logic [FRAME_W-1:0] key_q;
	logic               valid_q;
	logic               g_q;
	logic               e_q;
	logic               eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && g_q) begin
			key_q <= left_g ? left_key : frame;
		end else if (ctrl.rem && e_q) begin
			key_q <= right_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			g_q     <= 1'b0;
			e_q     <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctrl.ins && g_q) begin
				valid_q <= left_valid;
			end else if (ctrl.rem && e_q) begin
				valid_q <= right_valid;
			end
			if (ctrl.cmp) begin
				g_q  <= !valid_q || ($signed(key_q) > $signed(frame));
				e_q  <= !valid_q || ($signed(key_q) >= $signed(frame));
				eq_q <= valid_q && (key_q == frame);
			end
		end
	end

	assign key         = key_q;
	assign flags.valid = valid_q;
	assign flags.g     = g_q;
	assign flags.e     = e_q;
	assign flags.eq    = eq_q;

endmodule
`default_nettype wire

// ===== sv/sorted_keyframe_table.sv =====
// Sorted keyframe table: a row of compare-and-shift cells holding signed keys
// in ascending order, with a small sequencer for the commands.
// Depends on skft_pkg, skft_if and skft_cell.
//
// Usage:
//   req carries command and frame; rsp returns found, result_frame,
//   result_index, key_count and status, one response per request.
//   A request is taken only while the sequencer is idle. Each request runs
//   compare (every cell against the frame at once), select (one-hot boundary
//   search over the row) and execute (decision, shift of the row, response
//   write), in that order. The response is registered when execute completes,
//   and the next request is taken only after the sequencer is back in idle,
//   so a request is not taken before the last one has finished execute.
//   The response sits in an output register; the next request may be taken
//   while it waits. If rsp stalls, execute holds until the register frees.
//   Reset empties the table (all cell valid bits cleared, count zero) and
//   drops any pending response.
`default_nettype none
module sorted_keyframe_table
	import skft_pkg::*;
#(
	parameter int MAX_KEYS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	skft_req_if.sink   req,
	skft_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CMD_W-1:0]     cmd_s1;
	logic [FRAME_W-1:0]   frame_s1;

	cell_ctrl_t           ctrl;
	logic [FRAME_W-1:0]   key_vec [MAX_KEYS];
	cell_flags_t          flag_vec [MAX_KEYS];
	logic [MAX_KEYS-1:0]  valid_vec;
	logic [MAX_KEYS-1:0]  g_vec;
	logic [MAX_KEYS-1:0]  e_vec;
	logic [MAX_KEYS-1:0]  eq_vec;

	logic [IDX_W-1:0]     up_idx_s2;
	logic [FRAME_W-1:0]   up_key_s2;
	logic                 has_next_s2;
	logic [IDX_W-1:0]     lo_idx_s2;
	logic                 lo_hit_s2;
	logic [IDX_W-1:0]     prev_idx_s2;
	logic [FRAME_W-1:0]   prev_key_s2;
	logic                 has_prev_s2;

	logic                 out_valid_q;
	logic                 found_q;
	logic [FRAME_W-1:0]   rframe_q;
	logic [IDX_OUT_W-1:0] ridx_q;
	logic [CNT_OUT_W-1:0] rcount_q;
	status_t              status_q;

	logic                 exec_go;
	logic                 full;

	assign full    = (count_q == CNT_W'(MAX_KEYS));
	assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (req.valid) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_SEL;
				ST_SEL:  state_q <= ST_EXEC;
				ST_EXEC: if (exec_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1   <= req.command;
			frame_s1 <= req.frame;
		end
	end

	// cell row
	logic do_ins;
	logic do_rem;

	assign do_ins   = exec_go && (cmd_s1 == CMD_INSERT) && !full;
	assign do_rem   = exec_go && (cmd_s1 == CMD_REMOVE) && lo_hit_s2;
	assign ctrl.cmp = (state_q == ST_CMP);
	assign ctrl.ins = do_ins;
	assign ctrl.rem = do_rem;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic [FRAME_W-1:0] lk;
		logic               lv;
		logic               lg;
		logic [FRAME_W-1:0] rk;
		logic               rv;

		if (i == 0) begin : g_first
			assign lk = '0;
			assign lv = 1'b1;
			assign lg = 1'b0;
		end else begin : g_mid_l
			assign lk = key_vec[i-1];
			assign lv = flag_vec[i-1].valid;
			assign lg = flag_vec[i-1].g;
		end

		if (i == MAX_KEYS - 1) begin : g_last
			assign rk = '0;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rk = key_vec[i+1];
			assign rv = flag_vec[i+1].valid;
		end

		skft_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.frame       (frame_s1),
			.left_key    (lk),
			.left_valid  (lv),
			.left_g      (lg),
			.right_key   (rk),
			.right_valid (rv),
			.key         (key_vec[i]),
			.flags       (flag_vec[i])
		);

		assign valid_vec[i] = flag_vec[i].valid;
		assign g_vec[i]     = flag_vec[i].g;
		assign e_vec[i]     = flag_vec[i].e;
		assign eq_vec[i]    = flag_vec[i].eq;
	end

	// boundary search over the row
	logic [MAX_KEYS-1:0] lo_oh;
	logic [MAX_KEYS-1:0] up_oh;
	logic [MAX_KEYS-1:0] prev_oh;
	logic [IDX_W-1:0]    lo_idx;
	logic [IDX_W-1:0]    up_idx;
	logic [IDX_W-1:0]    prev_idx;
	logic [FRAME_W-1:0]  up_key;
	logic [FRAME_W-1:0]  prev_key;

	assign lo_oh   = e_vec & ~{e_vec[MAX_KEYS-2:0], 1'b0};
	assign up_oh   = g_vec & ~{g_vec[MAX_KEYS-2:0], 1'b0};
	assign prev_oh = ~e_vec & {1'b1, e_vec[MAX_KEYS-1:1]};

	always_comb begin
		lo_idx   = '0;
		up_idx   = '0;
		prev_idx = '0;
		up_key   = '0;
		prev_key = '0;
		for (int i = 0; i < MAX_KEYS; i++) begin
			lo_idx   = lo_idx | (lo_oh[i] ? IDX_W'(i) : '0);
			up_idx   = up_idx | (up_oh[i] ? IDX_W'(i) : '0);
			prev_idx = prev_idx | (prev_oh[i] ? IDX_W'(i) : '0);
			up_key   = up_key | ((up_oh[i] && valid_vec[i]) ? key_vec[i] : '0);
			prev_key = prev_key | (prev_oh[i] ? key_vec[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEL) begin
			lo_idx_s2   <= lo_idx;
			lo_hit_s2   <= |(lo_oh & eq_vec);
			up_idx_s2   <= up_idx;
			up_key_s2   <= up_key;
			has_next_s2 <= |(up_oh & valid_vec);
			prev_idx_s2 <= prev_idx;
			prev_key_s2 <= prev_key;
			has_prev_s2 <= !e_vec[0];
		end
	end

	// decision
	logic [FRAME_W:0]     dist_next;
	logic [FRAME_W:0]     dist_prev;
	logic                 take_prev;
	logic                 hit;
	logic [FRAME_W-1:0]   hit_frame;
	logic [IDX_W-1:0]     hit_idx;
	status_t              hit_status;
	logic [CNT_W-1:0]     count_next;

	assign dist_next = {up_key_s2[FRAME_W-1], up_key_s2} - {frame_s1[FRAME_W-1], frame_s1};
	assign dist_prev = {frame_s1[FRAME_W-1], frame_s1} - {prev_key_s2[FRAME_W-1], prev_key_s2};

	always_comb begin
		take_prev  = 1'b0;
		hit        = 1'b0;
		hit_frame  = '0;
		hit_idx    = '0;
		hit_status = STS_NOT_FOUND;
		count_next = count_q;
		case (cmd_s1)
			CMD_INSERT: begin
				if (full) begin
					hit_status = STS_FULL;
				end else begin
					hit        = 1'b1;
					hit_frame  = frame_s1;
					hit_idx    = up_idx_s2;
					hit_status = STS_OK;
					count_next = CNT_W'(count_q + 1'b1);
				end
			end
			CMD_REMOVE, CMD_FIND: begin
				if (lo_hit_s2) begin
					hit        = 1'b1;
					hit_frame  = frame_s1;
					hit_idx    = lo_idx_s2;
					hit_status = STS_OK;
					if (cmd_s1 == CMD_REMOVE) count_next = CNT_W'(count_q - 1'b1);
				end
			end
			CMD_NEXT, CMD_PREV, CMD_CLOSEST: begin
				if (cmd_s1 == CMD_PREV) begin
					take_prev = has_prev_s2;
				end else if (cmd_s1 == CMD_CLOSEST) begin
					if (has_next_s2 && has_prev_s2) take_prev = dist_next > dist_prev;
					else take_prev = has_prev_s2 && !has_next_s2;
				end
				if (take_prev) begin
					hit        = 1'b1;
					hit_frame  = prev_key_s2;
					hit_idx    = prev_idx_s2;
					hit_status = STS_OK;
				end else if (cmd_s1 != CMD_PREV && has_next_s2) begin
					hit        = 1'b1;
					hit_frame  = up_key_s2;
					hit_idx    = up_idx_s2;
					hit_status = STS_OK;
				end
			end
			default: hit_status = STS_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			found_q  <= hit;
			rframe_q <= hit_frame;
			ridx_q   <= IDX_OUT_W'(hit_idx);
			rcount_q <= CNT_OUT_W'(count_next);
			status_q <= hit_status;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = found_q;
	assign rsp.result_frame = rframe_q;
	assign rsp.result_index = ridx_q;
	assign rsp.key_count    = rcount_q;
	assign rsp.status       = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEYS))
		else $error("key count beyond capacity");

	a_row_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(((valid_vec + 1'b1) & valid_vec) == '0) &&
		($countones(valid_vec) == int'(count_q)))
		else $error("cell valid bits disagree with key count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the table");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("response raised outside execute");
`endif

endmodule
`default_nettype wire
